>>> hw/rtl/qnl_pkg.sv
// ---------------------------------------------------------------------------
// qnl_pkg: shared constants and types for the quaternion nlerp core
// Default field widths, the normalisation window and the queue status word.
// ---------------------------------------------------------------------------
`default_nettype none

package qnl_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 14;

  // blend magnitudes are scaled so the largest lies in [2^(NORM_BITS-1), 2^NORM_BITS)
  localparam int NORM_BITS  = 30;

  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/quaternion_nlerp_core.sv
// ---------------------------------------------------------------------------
// quaternion_nlerp_core: normalised linear interpolation of two quaternions
// Front blends on the shorter arc, a two-word queue decouples it from the
// back, which normalises through a bit-serial root and divider pipeline.
// ---------------------------------------------------------------------------
// Pipeline: the back holds the 31-stage root and the FRACTION_BITS + 2
//   stage divider.
// Throughput: one word per cycle; the back never stalls as the receiver
//   cannot hold results off, so busy stays low in use.
// Reset: synchronous rst empties all pipelines and the queue.
`default_nettype none

module quaternion_nlerp_core import qnl_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_BITS-1:0] first_x,
  input  logic signed [COMPONENT_BITS-1:0] first_y,
  input  logic signed [COMPONENT_BITS-1:0] first_z,
  input  logic signed [COMPONENT_BITS-1:0] first_w,
  input  logic signed [COMPONENT_BITS-1:0] second_x,
  input  logic signed [COMPONENT_BITS-1:0] second_y,
  input  logic signed [COMPONENT_BITS-1:0] second_z,
  input  logic signed [COMPONENT_BITS-1:0] second_w,
  input  logic        [FRACTION_BITS:0]    blend,
  output logic                             done,
  output logic signed [COMPONENT_BITS-1:0] out_x,
  output logic signed [COMPONENT_BITS-1:0] out_y,
  output logic signed [COMPONENT_BITS-1:0] out_z,
  output logic signed [COMPONENT_BITS-1:0] out_w,
  output logic                             degenerate
);

  localparam int WW = 4 * (COMPONENT_BITS + FRACTION_BITS + 2);

  logic          push;
  logic          pop;
  logic [WW-1:0] wdata;
  logic [WW-1:0] rdata;
  fifo_stat_t    stat;

  qnl_front #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .first_x  (first_x),
    .first_y  (first_y),
    .first_z  (first_z),
    .first_w  (first_w),
    .second_x (second_x),
    .second_y (second_y),
    .second_z (second_z),
    .second_w (second_w),
    .blend    (blend),
    .stat     (stat),
    .push     (push),
    .word     (wdata)
  );

  qnl_fifo #(
    .WIDTH (WW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .stat  (stat)
  );

  qnl_back #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .stat       (stat),
    .rdata      (rdata),
    .pop        (pop),
    .done       (done),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_w      (out_w),
    .degenerate (degenerate)
  );

endmodule

`default_nettype wire

>>> hw/rtl/qnl_fifo.sv
// ---------------------------------------------------------------------------
// qnl_fifo: short queue between front and back
// Register based, one word in and one word out per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module qnl_fifo import qnl_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fifo_stat_t       stat
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] entry [FIFO_DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CW'(1);
    end else if (!push && pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= bump(wp);
      end
      if (pop) begin
        rp <= bump(rp);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= wdata;
    end
  end

  assign rdata      = entry[rp];
  assign stat.full  = (count == CW'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("queue read while empty");
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(count))
    else $error("queue count moved with no traffic");

endmodule

`default_nettype wire

>>> hw/rtl/qnl_front.sv
// ---------------------------------------------------------------------------
// qnl_front: input stage, arc selection and exact blend
// Clamps t, takes the dot product sign and forms q1*(1-t) +/- q2*t.
// ---------------------------------------------------------------------------
`default_nettype none

module qnl_front import qnl_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  output logic                                         busy,
  input  logic signed [COMPONENT_BITS-1:0]             first_x,
  input  logic signed [COMPONENT_BITS-1:0]             first_y,
  input  logic signed [COMPONENT_BITS-1:0]             first_z,
  input  logic signed [COMPONENT_BITS-1:0]             first_w,
  input  logic signed [COMPONENT_BITS-1:0]             second_x,
  input  logic signed [COMPONENT_BITS-1:0]             second_y,
  input  logic signed [COMPONENT_BITS-1:0]             second_z,
  input  logic signed [COMPONENT_BITS-1:0]             second_w,
  input  logic        [FRACTION_BITS:0]                blend,
  input  fifo_stat_t                                   stat,
  output logic                                         push,
  output logic [4*(COMPONENT_BITS+FRACTION_BITS+2)-1:0] word
);

  localparam int C  = COMPONENT_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int VW = C + F + 2;
  localparam int DW = 2 * C + 2;
  localparam logic [F:0] UNIT = {1'b1, {F{1'b0}}};

  logic advance;
  logic signed [C-1:0] a_in [4];
  logic signed [C-1:0] b_in [4];
  logic [F:0] t_cl;

  logic v1, v2, v3, v4;
  logic signed [C-1:0] a1 [4];
  logic signed [C-1:0] b1 [4];
  logic [F:0] t1;
  logic signed [C-1:0] a2 [4];
  logic signed [C-1:0] b2 [4];
  logic [F:0] t2;
  logic signed [2*C-1:0] dp2 [4];
  logic flip3;
  logic signed [VW-1:0] pa3 [4];
  logic signed [VW-1:0] pb3 [4];
  logic signed [VW-1:0] vv4 [4];

  logic signed [DW-1:0] dsum;
  logic signed [F+1:0] inv_s;
  logic signed [F+1:0] t_s;

  assign advance = !stat.full;
  assign busy    = stat.full;

  assign a_in[0] = first_x;
  assign a_in[1] = first_y;
  assign a_in[2] = first_z;
  assign a_in[3] = first_w;
  assign b_in[0] = second_x;
  assign b_in[1] = second_y;
  assign b_in[2] = second_z;
  assign b_in[3] = second_w;

  assign t_cl  = (blend > UNIT) ? UNIT : blend;
  assign dsum  = DW'(dp2[0]) + DW'(dp2[1]) + DW'(dp2[2]) + DW'(dp2[3]);
  assign inv_s = $signed({1'b0, UNIT - t2});
  assign t_s   = $signed({1'b0, t2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t1 <= t_cl;
      t2 <= t1;
      // exact dot sum, zero keeps t positive
      flip3 <= dsum < 0;
      for (int i = 0; i < 4; i++) begin
        a1[i]  <= a_in[i];
        b1[i]  <= b_in[i];
        a2[i]  <= a1[i];
        b2[i]  <= b1[i];
        dp2[i] <= a1[i] * b1[i];
        pa3[i] <= a2[i] * inv_s;
        pb3[i] <= b2[i] * t_s;
        vv4[i] <= flip3 ? pa3[i] - pb3[i] : pa3[i] + pb3[i];
      end
    end
  end

  assign push = v4 && advance;
  assign word = {vv4[3], vv4[2], vv4[1], vv4[0]};

endmodule

`default_nettype wire

>>> hw/rtl/qnl_back.sv
// ---------------------------------------------------------------------------
// qnl_back: normalisation pipeline
// Scales the blend, sums squares, takes a rounded root one bit a stage and
// divides each component one quotient bit a stage, then saturates.
// ---------------------------------------------------------------------------
`default_nettype none

module qnl_back import qnl_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  fifo_stat_t                                    stat,
  input  logic [4*(COMPONENT_BITS+FRACTION_BITS+2)-1:0] rdata,
  output logic                                          pop,
  output logic                                          done,
  output logic signed [COMPONENT_BITS-1:0]              out_x,
  output logic signed [COMPONENT_BITS-1:0]              out_y,
  output logic signed [COMPONENT_BITS-1:0]              out_z,
  output logic signed [COMPONENT_BITS-1:0]              out_w,
  output logic                                          degenerate
);

  localparam int C     = COMPONENT_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int VW    = C + F + 2;
  localparam int MW    = VW - 1;
  localparam int PBW   = $clog2(MW);
  localparam int NB    = NORM_BITS;
  localparam int SW    = 2 * NB + 2;
  localparam int RB    = SW / 2;
  localparam int REMW  = RB + 3;
  localparam int RW    = RB + 1;
  localparam int NUMW  = NB + F + 1;
  localparam int QB    = F + 2;
  localparam int DRW   = RW + 1;
  localparam int SATW  = ((QB > C) ? QB : C) + 1;
  localparam int BACK_LAT = RB + QB + 8;

  typedef struct packed {
    logic [3:0][NB-1:0] m;
    logic [3:0]         sg;
    logic               deg;
  } side_t;

  typedef struct packed {
    logic [3:0] sg;
    logic       deg;
  } dside_t;

  function automatic logic [PBW-1:0] msb_pos(input logic [MW-1:0] v);
    logic [PBW-1:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (v[i]) begin
        p = PBW'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [C-1:0] saturate(input logic [QB-1:0] q, input logic neg);
    logic [SATW-1:0] qe;
    logic [SATW-1:0] pmax;
    logic [SATW-1:0] qs;
    qe   = SATW'(q);
    pmax = (SATW'(1) << (C - 1)) - SATW'(1);
    if (neg) begin
      qs = (qe > pmax + SATW'(1)) ? pmax + SATW'(1) : qe;
      return C'(~qs + SATW'(1));
    end
    qs = (qe > pmax) ? pmax : qe;
    return C'(qs);
  endfunction

  // ---- scale and square ----
  logic signed [VW-1:0] vin [4];
  logic [MW-1:0] mag [4];
  logic [MW-1:0] mag_or;

  logic b1_v, b2_v, b3_v, b4_v, b5_v;
  logic [MW-1:0] m1 [4];
  logic [MW-1:0] or1;
  logic [3:0] sg1, sg2, sg3, sg4, sg5;
  logic deg1, deg2, deg3, deg4, deg5;
  logic [MW-1:0] m2 [4];
  logic [PBW-1:0] p2;
  logic [NB-1:0] n3 [4];
  logic [NB-1:0] n4 [4];
  logic [NB-1:0] n5 [4];
  logic [2*NB-1:0] sq4 [4];
  logic [SW-1:0] s5;

  assign pop = !stat.empty;

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 4; i++) begin
      vin[i] = $signed(rdata[i*VW +: VW]);
      mag[i] = MW'(vin[i][VW-1] ? -vin[i] : vin[i]);
      mag_or = mag_or | mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      b5_v <= 1'b0;
    end else begin
      b1_v <= pop;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      b5_v <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    or1  <= mag_or;
    deg1 <= (mag_or == '0);
    deg2 <= deg1;
    deg3 <= deg2;
    deg4 <= deg3;
    deg5 <= deg4;
    p2   <= msb_pos(or1);
    s5   <= SW'(sq4[0]) + SW'(sq4[1]) + SW'(sq4[2]) + SW'(sq4[3]);
    for (int i = 0; i < 4; i++) begin
      m1[i]  <= mag[i];
      sg1[i] <= vin[i][VW-1];
      m2[i]  <= m1[i];
      // left or truncating right shift in one move: m * 2^(NB-1-p)
      n3[i]  <= NB'({m2[i], {(NB-1){1'b0}}} >> p2);
      n4[i]  <= n3[i];
      n5[i]  <= n4[i];
      sq4[i] <= n3[i] * n3[i];
    end
    sg2 <= sg1;
    sg3 <= sg2;
    sg4 <= sg3;
    sg5 <= sg4;
  end

  // ---- square root, one result bit a stage ----
  logic [REMW-1:0] sq_rem  [RB];
  logic [RB-1:0]   sq_root [RB];
  logic [SW-1:0]   sq_s    [RB];
  side_t           sq_sd   [RB];
  logic            sq_v    [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [REMW-1:0] rem_i;
    logic [RB-1:0]   root_i;
    logic [SW-1:0]   s_i;
    side_t           sd_i;
    logic            v_i;
    logic [REMW-1:0] rr;
    logic [REMW-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = s5;
      assign v_i    = b5_v;
      assign sd_i.m = {n5[3], n5[2], n5[1], n5[0]};
      assign sd_i.sg  = sg5;
      assign sd_i.deg = deg5;
    end else begin : g_next
      assign rem_i  = sq_rem[j-1];
      assign root_i = sq_root[j-1];
      assign s_i    = sq_s[j-1];
      assign v_i    = sq_v[j-1];
      assign sd_i   = sq_sd[j-1];
    end

    assign rr    = {rem_i[REMW-3:0], s_i[SW-1-2*j -: 2]};
    assign trial = REMW'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else begin
        sq_v[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      sq_s[j]  <= s_i;
      sq_sd[j] <= sd_i;
      if (rr >= trial) begin
        sq_rem[j]  <= rr - trial;
        sq_root[j] <= {root_i[RB-2:0], 1'b1};
      end else begin
        sq_rem[j]  <= rr;
        sq_root[j] <= {root_i[RB-2:0], 1'b0};
      end
    end
  end

  // ---- round root, form numerators ----
  logic r6_v, r7_v;
  logic [RW-1:0] r6, r7;
  side_t sd6;
  dside_t sd7;
  logic [NUMW-1:0] nm7 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      r6_v <= 1'b0;
      r7_v <= 1'b0;
    end else begin
      r6_v <= sq_v[RB-1];
      r7_v <= r6_v;
    end
  end

  always_ff @(posedge clk) begin
    // round up when the remainder exceeds the integer root
    r6  <= RW'(sq_root[RB-1]) + RW'(sq_rem[RB-1] > REMW'(sq_root[RB-1]));
    sd6 <= sq_sd[RB-1];
    r7  <= r6;
    sd7.sg  <= sd6.sg;
    sd7.deg <= sd6.deg;
    for (int i = 0; i < 4; i++) begin
      nm7[i] <= NUMW'({sd6.m[i], {F{1'b0}}}) + NUMW'(r6 >> 1);
    end
  end

  // ---- restoring division, one quotient bit a stage ----
  logic [RW-1:0] dv_rem [QB][4];
  logic [QB-1:0] dv_low [QB][4];
  logic [QB-1:0] dv_q   [QB][4];
  logic [RW-1:0] dv_r   [QB];
  dside_t        dv_sd  [QB];
  logic          dv_v   [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] r_i;
    dside_t        sd_i;
    logic          v_i;

    if (k == 0) begin : g_first
      assign r_i  = r7;
      assign sd_i = sd7;
      assign v_i  = r7_v;
    end else begin : g_next
      assign r_i  = dv_r[k-1];
      assign sd_i = dv_sd[k-1];
      assign v_i  = dv_v[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k] <= 1'b0;
      end else begin
        dv_v[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      dv_r[k]  <= r_i;
      dv_sd[k] <= sd_i;
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [RW-1:0]  rem_i;
      logic [QB-1:0]  low_i;
      logic [QB-1:0]  q_i;
      logic [DRW-1:0] rr;

      if (k == 0) begin : g_first
        // the quotient fits QB bits, so the top bits start as the remainder
        assign rem_i = RW'(nm7[i][NUMW-1:QB]);
        assign low_i = nm7[i][QB-1:0];
        assign q_i   = '0;
      end else begin : g_next
        assign rem_i = dv_rem[k-1][i];
        assign low_i = dv_low[k-1][i];
        assign q_i   = dv_q[k-1][i];
      end

      assign rr = {rem_i, low_i[QB-1]};

      always_ff @(posedge clk) begin
        dv_low[k][i] <= {low_i[QB-2:0], 1'b0};
        if (rr >= DRW'(r_i)) begin
          dv_rem[k][i] <= RW'(rr - DRW'(r_i));
          dv_q[k][i]   <= {q_i[QB-2:0], 1'b1};
        end else begin
          dv_rem[k][i] <= RW'(rr);
          dv_q[k][i]   <= {q_i[QB-2:0], 1'b0};
        end
      end
    end
  end

  // ---- saturate and present ----
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_v[QB-1]) begin
      degenerate <= dv_sd[QB-1].deg;
      if (dv_sd[QB-1].deg) begin
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
        out_w <= '0;
      end else begin
        out_x <= saturate(dv_q[QB-1][0], dv_sd[QB-1].sg[0]);
        out_y <= saturate(dv_q[QB-1][1], dv_sd[QB-1].sg[1]);
        out_z <= saturate(dv_q[QB-1][2], dv_sd[QB-1].sg[2]);
        out_w <= saturate(dv_q[QB-1][3], dv_sd[QB-1].sg[3]);
      end
    end
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    pop |-> ##(BACK_LAT) done)
    else $error("word popped but no result after the pipeline depth");
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
    else $error("degenerate result with non-zero components");

endmodule

`default_nettype wire
